/* hdl/ncc_pkg.sv */
package ncc_pkg;

    localparam int MAX_ENTRIES  = 16;
    localparam int CHANNEL_BITS = 16;
    localparam int LABEL_W      = 8;
    localparam int COLOR_W      = 16;
    localparam int DIST_W       = 34;

    localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int SQ_W    = 2 * CHANNEL_BITS;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ENTRY_W = 3 * CHANNEL_BITS + LABEL_W;

    localparam logic OP_TRAIN    = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef logic [LABEL_W-1:0]      label_t;
    typedef logic [SUM_W-1:0]        sum_t;

    typedef struct packed {
        label_t label;
        chan_t  red;
        chan_t  green;
        chan_t  blue;
    } entry_t;

    typedef struct packed {
        logic valid;
        logic last;
    } scan_tag_t;

    typedef struct packed {
        logic   valid;
        logic   last;
        label_t label;
        sum_t   dist_sq;
    } dist_res_t;

endpackage

/* hdl/ncc_req_if.sv */
interface ncc_req_if;
    import ncc_pkg::*;

    logic               valid;
    logic               ready;
    logic               opcode;
    logic [COLOR_W-1:0] color_blue;
    logic [COLOR_W-1:0] color_green;
    logic [COLOR_W-1:0] color_red;
    logic [LABEL_W-1:0] label_in;

    modport source (
        output valid, opcode, color_blue, color_green, color_red, label_in,
        input  ready
    );

    modport sink (
        input  valid, opcode, color_blue, color_green, color_red, label_in,
        output ready
    );

endinterface

/* hdl/ncc_rsp_if.sv */
interface ncc_rsp_if;
    import ncc_pkg::*;

    logic              valid;
    logic              ready;
    logic              match_found;
    logic [LABEL_W-1:0] label_out;
    logic [DIST_W-1:0] best_distance_sq;
    logic              status;

    modport source (
        output valid, match_found, label_out, best_distance_sq, status,
        input  ready
    );

    modport sink (
        input  valid, match_found, label_out, best_distance_sq, status,
        output ready
    );

endinterface

/* hdl/nearest_color_classifier_top.sv */
// Channel  Direction  Handshake     Payload
// req      in         valid/ready   opcode, color_blue, color_green, color_red, label_in
// rsp      out        valid/ready   match_found, label_out, best_distance_sq, status
//
// A train item, or a classify item on an empty table, goes straight from idle to the done state;
// a classify item over the stored entries scans them all and waits for the last distance, its pace
// set by the single read port of the entry memory feeding a two-stage distance pipeline.
// Each result reaches the output register in the same cycle that the block becomes ready again.
// Reset clears the entry count, so the entry memory itself needs no clearing.
// A result waiting in the output register stalls the block only when the next one is done.
module nearest_color_classifier_top (
    input logic      clk,
    input logic      rst_n,
    ncc_req_if.sink  req,
    ncc_rsp_if.source rsp
);
    import ncc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    scan_tag_t        tag_reg;
    scan_tag_t        tag_next;
    logic             have_reg;
    logic             have_next;
    sum_t             best_reg;
    sum_t             best_next;
    label_t           best_label_reg;
    label_t           best_label_next;

    chan_t            q_blue_reg;
    chan_t            q_green_reg;
    chan_t            q_red_reg;

    logic             res_match_reg;
    logic             res_match_next;
    label_t           res_label_reg;
    label_t           res_label_next;
    sum_t             res_dist_reg;
    sum_t             res_dist_next;
    logic             res_status_reg;
    logic             res_status_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_match_reg;
    label_t           out_label_reg;
    sum_t             out_dist_reg;
    logic             out_status_reg;

    logic             accept;
    logic             full;
    logic             scan_last;
    logic             out_load;
    logic             take;
    logic             ram_we;
    logic             ram_re;
    entry_t           wr_entry;
    logic [ENTRY_W-1:0] rd_data;
    dist_res_t        dres;

    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(MAX_ENTRIES));
    assign scan_last = (CNT_W'(idx_reg) == count_reg - CNT_W'(1));
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);
    assign take      = !have_reg || (dres.dist_sq < best_reg);

    assign req.ready = (state_reg == S_IDLE);

    assign ram_we         = accept && (req.opcode == OP_TRAIN) && !full;
    assign ram_re         = (state_reg == S_SCAN);
    assign wr_entry.label = req.label_in;
    assign wr_entry.red   = chan_t'(req.color_red);
    assign wr_entry.green = chan_t'(req.color_green);
    assign wr_entry.blue  = chan_t'(req.color_blue);

    ncc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IDX_W'(count_reg)),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    ncc_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_blue  (q_blue_reg),
        .q_green (q_green_reg),
        .q_red   (q_red_reg),
        .entry   (entry_t'(rd_data)),
        .tag     (tag_reg),
        .res     (dres)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        tag_next        = '0;
        have_next       = have_reg;
        best_next       = best_reg;
        best_label_next = best_label_reg;
        res_match_next  = res_match_reg;
        res_label_next  = res_label_reg;
        res_dist_next   = res_dist_reg;
        res_status_next = res_status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_match_next  = 1'b0;
                    res_label_next  = '0;
                    res_dist_next   = '0;
                    res_status_next = STATUS_OK;
                    idx_next        = '0;
                    have_next       = 1'b0;
                    if (req.opcode == OP_TRAIN)
                    begin
                        if (full)
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        state_next = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                tag_next.valid = 1'b1;
                tag_next.last  = scan_last;
                idx_next       = idx_reg + IDX_W'(1);
                if (scan_last)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (dres.valid && dres.last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (dres.valid && take)
        begin
            have_next       = 1'b1;
            best_next       = dres.dist_sq;
            best_label_next = dres.label;
        end
        if (dres.valid && dres.last)
        begin
            res_match_next = 1'b1;
            res_label_next = best_label_next;
            res_dist_next  = best_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            tag_reg       <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            tag_reg       <= tag_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg       <= best_next;
        best_label_reg <= best_label_next;
        res_match_reg  <= res_match_next;
        res_label_reg  <= res_label_next;
        res_dist_reg   <= res_dist_next;
        res_status_reg <= res_status_next;
        if (accept)
        begin
            q_blue_reg  <= chan_t'(req.color_blue);
            q_green_reg <= chan_t'(req.color_green);
            q_red_reg   <= chan_t'(req.color_red);
        end
        if (out_load)
        begin
            out_match_reg  <= res_match_reg;
            out_label_reg  <= res_label_reg;
            out_dist_reg   <= res_dist_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.match_found      = out_match_reg;
    assign rsp.label_out        = out_label_reg;
    assign rsp.best_distance_sq = DIST_W'(out_dist_reg);
    assign rsp.status           = out_status_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count exceeds the table size");

    a_full_train_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.opcode == OP_TRAIN && full) |=> $stable(count_reg))
        else $error("rejected train item changed the entry count");

    a_dist_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dres.valid |-> (state_reg == S_SCAN || state_reg == S_WAIT))
        else $error("distance result outside a scan");

    a_empty_classify_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.opcode == OP_CLASSIFY && count_reg == '0) |=> state_reg == S_DONE)
        else $error("classify on empty table did not finish at once");
`endif

endmodule

/* hdl/ncc_ram.sv */
module ncc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/ncc_dist.sv */
module ncc_dist (
    input  logic               clk,
    input  logic               rst_n,
    input  ncc_pkg::chan_t     q_blue,
    input  ncc_pkg::chan_t     q_green,
    input  ncc_pkg::chan_t     q_red,
    input  ncc_pkg::entry_t    entry,
    input  ncc_pkg::scan_tag_t tag,
    output ncc_pkg::dist_res_t res
);
    import ncc_pkg::*;

    chan_t       d_blue;
    chan_t       d_green;
    chan_t       d_red;
    logic [SQ_W-1:0] sq_blue_reg;
    logic [SQ_W-1:0] sq_green_reg;
    logic [SQ_W-1:0] sq_red_reg;
    label_t      label_reg;
    scan_tag_t   tag_reg;
    scan_tag_t   tag2_reg;
    label_t      label2_reg;
    sum_t        sum_reg;

    always_comb
    begin
        d_blue  = (entry.blue >= q_blue) ? entry.blue - q_blue : q_blue - entry.blue;
        d_green = (entry.green >= q_green) ? entry.green - q_green : q_green - entry.green;
        d_red   = (entry.red >= q_red) ? entry.red - q_red : q_red - entry.red;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg  <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag_reg  <= tag;
            tag2_reg <= tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_blue_reg  <= SQ_W'(d_blue) * SQ_W'(d_blue);
        sq_green_reg <= SQ_W'(d_green) * SQ_W'(d_green);
        sq_red_reg   <= SQ_W'(d_red) * SQ_W'(d_red);
        label_reg    <= entry.label;
        sum_reg      <= SUM_W'(sq_blue_reg) + SUM_W'(sq_green_reg) + SUM_W'(sq_red_reg);
        label2_reg   <= label_reg;
    end

    assign res.valid   = tag2_reg.valid;
    assign res.last    = tag2_reg.last;
    assign res.label   = label2_reg;
    assign res.dist_sq = sum_reg;

endmodule
